@@ rtl/bg_pkg.sv @@
// Shared types and constants for the 8x8 bit grid unit.
// No dependencies; the files that use it refer to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package bg_pkg;

	localparam int unsigned GRID_W = 64;
	localparam int unsigned SIDE   = 8;

	localparam logic [3:0] OP_LOAD      = 4'd0;
	localparam logic [3:0] OP_AND       = 4'd1;
	localparam logic [3:0] OP_ANDNOT    = 4'd2;
	localparam logic [3:0] OP_OR        = 4'd3;
	localparam logic [3:0] OP_XOR       = 4'd4;
	localparam logic [3:0] OP_INVERT    = 4'd5;
	localparam logic [3:0] OP_SETROW    = 4'd6;
	localparam logic [3:0] OP_SETCOL    = 4'd7;
	localparam logic [3:0] OP_SHL       = 4'd8;
	localparam logic [3:0] OP_SHR       = 4'd9;
	localparam logic [3:0] OP_SHUP      = 4'd10;
	localparam logic [3:0] OP_SHDN      = 4'd11;
	localparam logic [3:0] OP_TRANSPOSE = 4'd12;
	localparam logic [3:0] OP_ROWFLIP   = 4'd13;
	localparam logic [3:0] OP_BITFLIP   = 4'd14;
	localparam logic [3:0] OP_QUERY     = 4'd15;

	localparam logic [1:0] KIND_GRID  = 2'd0;
	localparam logic [1:0] KIND_RECT  = 2'd1;
	localparam logic [1:0] KIND_POINT = 2'd2;

	localparam logic [63:0] COL0_MASK = 64'h0101_0101_0101_0101;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [1:0]  operand_kind;
		logic [63:0] grid_operand;
		logic [2:0]  x_low;
		logic [2:0]  x_high;
		logic [2:0]  y_low;
		logic [2:0]  y_high;
		logic [3:0]  index;
		logic [7:0]  bits_value;
	} bg_cmd_t;

	typedef struct packed {
		logic [7:0] row;
		logic [7:0] column;
		logic [6:0] count;
		logic       empty;
		logic       full;
	} bg_stats_t;

endpackage

`default_nettype wire

@@ rtl/bg_cmd_if.sv @@
// Command channel of the bit grid unit: valid/ready plus the item fields.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface bg_cmd_if;
	logic        valid;
	logic        ready;
	logic [3:0]  opcode;
	logic [1:0]  operand_kind;
	logic [63:0] grid_operand;
	logic [2:0]  x_low;
	logic [2:0]  x_high;
	logic [2:0]  y_low;
	logic [2:0]  y_high;
	logic [3:0]  index;
	logic [7:0]  bits_value;

	modport source (
		output valid, opcode, operand_kind, grid_operand, x_low, x_high,
			y_low, y_high, index, bits_value,
		input  ready
	);
	modport sink (
		input  valid, opcode, operand_kind, grid_operand, x_low, x_high,
			y_low, y_high, index, bits_value,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/bg_res_if.sv @@
// Result channel of the bit grid unit: valid/ready plus the result fields.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface bg_res_if;
	logic        valid;
	logic        ready;
	logic [63:0] grid_out;
	logic [7:0]  row_out;
	logic [7:0]  column_out;
	logic [6:0]  set_count;
	logic        is_empty;
	logic        is_full;

	modport source (
		output valid, grid_out, row_out, column_out, set_count, is_empty, is_full,
		input  ready
	);
	modport sink (
		input  valid, grid_out, row_out, column_out, set_count, is_empty, is_full,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/bg_operand.sv @@
// Boolean operand builder: grid word, rectangle mask or single point.
// Depends on bg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bg_operand (
	input  wire bg_pkg::bg_cmd_t cmd,
	output logic [63:0]          operand
);

	logic [7:0]  col_sel;
	logic [7:0]  row_sel;
	logic [63:0] rect;
	logic [63:0] point;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			col_sel[i] = (3'(i) >= cmd.x_low) && (3'(i) <= cmd.x_high);
			row_sel[i] = (3'(i) >= cmd.y_low) && (3'(i) <= cmd.y_high);
		end
		for (int r = 0; r < 8; r++) begin
			for (int c = 0; c < 8; c++) begin
				rect[r*8+c] = row_sel[r] & col_sel[c];
			end
		end
		point = 64'd1 << {cmd.y_low, cmd.x_low};
	end

	always_comb begin
		case (cmd.operand_kind)
			bg_pkg::KIND_GRID:  operand = cmd.grid_operand;
			bg_pkg::KIND_RECT:  operand = rect;
			bg_pkg::KIND_POINT: operand = point;
			default:            operand = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/bg_alu.sv @@
// Next-grid logic: applies one opcode to the current grid.
// Depends on bg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bg_alu (
	input  wire bg_pkg::bg_cmd_t cmd,
	input  wire [63:0]           grid,
	input  wire [63:0]           operand,
	output logic [63:0]          grid_next
);

	logic        idx_ok;
	logic [2:0]  amt;
	logic [63:0] set_row;
	logic [63:0] set_col;
	logic [63:0] shl;
	logic [63:0] shr;
	logic [63:0] trans;
	logic [63:0] rflip;
	logic [63:0] bflip;

	assign idx_ok = ~cmd.index[3];
	assign amt    = cmd.index[2:0];

	always_comb begin
		set_row = grid;
		set_row[amt*8 +: 8] = cmd.bits_value;
		set_col = grid & ~(bg_pkg::COL0_MASK << amt);
		for (int r = 0; r < 8; r++) begin
			set_col[r*8 + amt] = cmd.bits_value[r];
			shl[r*8 +: 8]       = grid[r*8 +: 8] << amt;
			shr[r*8 +: 8]       = grid[r*8 +: 8] >> amt;
			rflip[(7-r)*8 +: 8] = grid[r*8 +: 8];
			for (int c = 0; c < 8; c++) begin
				trans[r*8+c]       = grid[c*8+r];
				bflip[r*8 + 7 - c] = grid[r*8+c];
			end
		end
	end

	always_comb begin
		unique case (cmd.opcode)
			bg_pkg::OP_LOAD:      grid_next = cmd.grid_operand;
			bg_pkg::OP_AND:       grid_next = grid & operand;
			bg_pkg::OP_ANDNOT:    grid_next = grid & ~operand;
			bg_pkg::OP_OR:        grid_next = grid | operand;
			bg_pkg::OP_XOR:       grid_next = grid ^ operand;
			bg_pkg::OP_INVERT:    grid_next = ~grid;
			bg_pkg::OP_SETROW:    grid_next = idx_ok ? set_row : grid;
			bg_pkg::OP_SETCOL:    grid_next = idx_ok ? set_col : grid;
			bg_pkg::OP_SHL:       grid_next = idx_ok ? shl : '0;
			bg_pkg::OP_SHR:       grid_next = idx_ok ? shr : '0;
			bg_pkg::OP_SHUP:      grid_next = idx_ok ? (grid >> {amt, 3'b000}) : '0;
			bg_pkg::OP_SHDN:      grid_next = idx_ok ? (grid << {amt, 3'b000}) : '0;
			bg_pkg::OP_TRANSPOSE: grid_next = trans;
			bg_pkg::OP_ROWFLIP:   grid_next = rflip;
			bg_pkg::OP_BITFLIP:   grid_next = bflip;
			default:              grid_next = grid;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/bg_stats.sv @@
// Result statistics: selected row and column, popcount, empty and full flags.
// Depends on bg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bg_stats (
	input  wire [63:0]          grid,
	input  wire [3:0]           index,
	output bg_pkg::bg_stats_t   stats
);

	logic [1:0] cnt2  [32];
	logic [2:0] cnt4  [16];
	logic [3:0] cnt8  [8];
	logic [4:0] cnt16 [4];
	logic [5:0] cnt32 [2];
	logic [2:0] amt;
	logic [7:0] col;

	assign amt = index[2:0];

	// popcount as a balanced adder tree
	always_comb begin
		for (int i = 0; i < 32; i++) begin
			cnt2[i] = {1'b0, grid[2*i]} + {1'b0, grid[2*i+1]};
		end
		for (int i = 0; i < 16; i++) begin
			cnt4[i] = {1'b0, cnt2[2*i]} + {1'b0, cnt2[2*i+1]};
		end
		for (int i = 0; i < 8; i++) begin
			cnt8[i] = {1'b0, cnt4[2*i]} + {1'b0, cnt4[2*i+1]};
		end
		for (int i = 0; i < 4; i++) begin
			cnt16[i] = {1'b0, cnt8[2*i]} + {1'b0, cnt8[2*i+1]};
		end
		for (int i = 0; i < 2; i++) begin
			cnt32[i] = {1'b0, cnt16[2*i]} + {1'b0, cnt16[2*i+1]};
		end
		for (int r = 0; r < 8; r++) begin
			col[r] = grid[r*8 + amt];
		end
		stats.count  = {1'b0, cnt32[0]} + {1'b0, cnt32[1]};
		stats.row    = index[3] ? 8'd0 : grid[amt*8 +: 8];
		stats.column = index[3] ? 8'd0 : col;
		stats.empty  = (grid == '0);
		stats.full   = &grid;
	end

endmodule

`default_nettype wire

@@ rtl/bit_grid_8x8_unit.sv @@
// Bit grid unit: holds an 8x8 grid (cell column c, row r at bit r*8+c) and
// applies one opcode per transaction, returning one result per command. It
// takes one command every cycle while results are accepted; each command
// passes through the input register and then the result register before
// its result is offered. The rate is set by the loop from the grid register
// through the opcode logic back into itself. Backpressure on the result
// side stalls the command side only once both registers are occupied.
// Reset clears the grid.
// Depends on bg_pkg, bg_cmd_if, bg_res_if, bg_operand, bg_alu and bg_stats.
`timescale 1ns / 1ps
`default_nettype none

module bit_grid_8x8_unit (
	input  wire      clk,
	input  wire      arst_n,
	bg_cmd_if.sink   cmd,
	bg_res_if.source res
);

	bg_pkg::bg_cmd_t   cmd_s1;
	logic              valid_s1;
	logic              valid_s2;
	logic [63:0]       grid_s2;
	bg_pkg::bg_stats_t stats_s2;
	logic [63:0]       grid_q;

	logic [63:0]       operand;
	logic [63:0]       grid_next;
	bg_pkg::bg_stats_t stats_next;
	logic              load_s2;
	logic              adv_s1;

	assign load_s2   = ~valid_s2 | res.ready;
	assign adv_s1    = valid_s1 & load_s2;
	assign cmd.ready = ~valid_s1 | adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			grid_q   <= '0;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				grid_q <= grid_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1.opcode       <= cmd.opcode;
			cmd_s1.operand_kind <= cmd.operand_kind;
			cmd_s1.grid_operand <= cmd.grid_operand;
			cmd_s1.x_low        <= cmd.x_low;
			cmd_s1.x_high       <= cmd.x_high;
			cmd_s1.y_low        <= cmd.y_low;
			cmd_s1.y_high       <= cmd.y_high;
			cmd_s1.index        <= cmd.index;
			cmd_s1.bits_value   <= cmd.bits_value;
		end
		if (adv_s1) begin
			grid_s2  <= grid_next;
			stats_s2 <= stats_next;
		end
	end

	bg_operand u_operand (
		.cmd     (cmd_s1),
		.operand (operand)
	);

	bg_alu u_alu (
		.cmd       (cmd_s1),
		.grid      (grid_q),
		.operand   (operand),
		.grid_next (grid_next)
	);

	bg_stats u_stats (
		.grid  (grid_next),
		.index (cmd_s1.index),
		.stats (stats_next)
	);

	assign res.valid      = valid_s2;
	assign res.grid_out   = grid_s2;
	assign res.row_out    = stats_s2.row;
	assign res.column_out = stats_s2.column;
	assign res.set_count  = stats_s2.count;
	assign res.is_empty   = stats_s2.empty;
	assign res.is_full    = stats_s2.full;

`ifndef SYNTHESIS
	// a pending result always reflects the current grid state
	a_grid_match: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (grid_s2 == grid_q))
		else $error("pending result grid differs from grid register");

	a_count_flags: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((stats_s2.empty == (stats_s2.count == 7'd0)) &&
			(stats_s2.full == (stats_s2.count == 7'd64))))
		else $error("popcount disagrees with empty/full flags");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> cmd.ready)
		else $error("command stalled while result register is free");

	a_grid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(grid_q))
		else $error("grid changed without a command advancing");
`endif

endmodule

`default_nettype wire
